// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the ring buffer stamper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while arst_n is low.
`define RWSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, during reset too.
`define RWSC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rwsc_pkg.sv =====
// Types and constants shared by the ring buffer write stamper modules.
package rwsc_pkg;

	// Largest message that must still fit behind the write offset.
	localparam int unsigned MAX_MESSAGE_BYTES = 8192;
	localparam logic [63:0] MSG_LIMIT = 64'(MAX_MESSAGE_BYTES);

	// Messages are placed on 64-byte boundaries.
	localparam int unsigned ALIGN_BITS = 6;
	localparam logic [63:0] ALIGN_MASK = (64'd1 << ALIGN_BITS) - 64'd1;

	// Fields kept in a write request.
	localparam int unsigned ADDR_BITS = 48;
	localparam int unsigned LEN_BITS  = 28;

	// APB port geometry: 64-bit registers at byte addresses 0 and 8.
	localparam int unsigned APB_DATA_W  = 64;
	localparam int unsigned PADDR_W     = 4;
	localparam int unsigned REG_SEL_BIT = 3;

	localparam int unsigned NUM_LANES = 8;
	localparam int unsigned LANE_W    = 64;

	typedef enum logic [1:0] {
		REQ_LENGTH = 2'd0,
		REQ_DATA   = 2'd1,
		REQ_START  = 2'd2
	} req_type_t;

	typedef enum logic {
		REG_BASE = 1'b0,
		REG_SIZE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_REQUEST = 1'b0,
		KIND_DATA    = 1'b1
	} out_kind_t;

	// Configuration as seen by the datapath; the room check is precomputed.
	typedef struct packed {
		logic [63:0] base_address;
		logic [63:0] room_limit;  // buffer_size - MAX_MESSAGE_BYTES
		logic        room_ok;     // buffer_size > MAX_MESSAGE_BYTES
	} cfg_t;

	typedef struct packed {
		logic [1:0]                        req_type;
		logic [31:0]                       msg_length;
		logic [NUM_LANES-1:0][LANE_W-1:0]  lane;
		logic [63:0]                       keep;
		logic                              last;
	} item_t;

	typedef struct packed {
		logic                              kind;
		logic [NUM_LANES-1:0][LANE_W-1:0]  lane;
		logic [63:0]                       keep;
		logic                              last;
	} result_t;

endpackage

// ===== rtl/core/rwsc_cfg.sv =====
// APB register file: base address and buffer size with precomputed room limit.
module rwsc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rwsc_pkg::PADDR_W-1:0]    paddr,
	input  logic [rwsc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rwsc_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output rwsc_pkg::cfg_t                  cfg
);
	import rwsc_pkg::*;

	logic [63:0] base_q;
	logic [63:0] size_q;
	logic [63:0] room_limit_q;
	logic        room_ok_q;
	logic        wr_en;
	reg_idx_t    sel;

	// Register select ignores the byte offset inside a 64-bit register
	assign sel    = reg_idx_t'(paddr[REG_SEL_BIT]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes; the wrap threshold is derived on each size register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			size_q       <= '0;
			room_limit_q <= '0;
			room_ok_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (sel)
				REG_BASE: begin
					base_q <= pwdata;
				end
				REG_SIZE: begin
					size_q       <= pwdata;
					room_limit_q <= pwdata - MSG_LIMIT;
					room_ok_q    <= pwdata > MSG_LIMIT;
				end
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (sel)
			REG_BASE: prdata = base_q;
			REG_SIZE: prdata = size_q;
			default:  prdata = '0;
		endcase
	end

	assign cfg.base_address = base_q;
	assign cfg.room_limit   = room_limit_q;
	assign cfg.room_ok      = room_ok_q;

endmodule

// ===== rtl/core/rwsc_in_reg.sv =====
// Input register: holds one accepted transaction for the stamping stage.
module rwsc_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rwsc_pkg::item_t in_item,
	output rwsc_pkg::item_t item_s1,
	output logic            valid_s1,
	input  logic            pop_s1
);
	import rwsc_pkg::*;

	logic load;

	// Refill in the same cycle the held item moves on
	assign in_ready = !valid_s1 || pop_s1;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (pop_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/core/rwsc_stamp.sv =====
// Stamping stage: phase tracking, offset/wrap update and the result register.
module rwsc_stamp (
	input  logic              clk,
	input  logic              arst_n,
	input  rwsc_pkg::cfg_t    cfg,
	input  rwsc_pkg::item_t   item_s1,
	input  logic              valid_s1,
	output logic              pop_s1,
	output rwsc_pkg::result_t result_s2,
	output logic              valid_s2,
	input  logic              out_ready
);
	import rwsc_pkg::*;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_HEAD,
		PH_DATA
	} phase_t;

	phase_t      phase_q;
	logic [63:0] offset_q;
	logic [63:0] seq_q;
	logic        wrap_q;

	logic        take;
	logic [63:0] adv_sum;
	logic [63:0] next_offset;
	logic [63:0] req_addr;
	logic        room;

	phase_t      phase_next;
	logic [63:0] offset_next;
	logic [63:0] seq_next;
	logic        wrap_next;
	logic        emit;
	result_t     res_next;

	logic        len_take;
	logic        head_take;

	// Item moves on when the result register is empty or drains this cycle
	assign take   = valid_s1 && (!valid_s2 || out_ready);
	assign pop_s1 = take;

	// Offset advance rounded up to 64 bytes, and the room check
	assign adv_sum     = offset_q + {32'd0, item_s1.msg_length} + ALIGN_MASK;
	assign next_offset = adv_sum & ~ALIGN_MASK;
	assign room        = cfg.room_ok && (next_offset < cfg.room_limit);
	assign req_addr    = cfg.base_address + offset_q;

	// Next state and result for the held transaction
	always_comb begin
		phase_next  = phase_q;
		offset_next = offset_q;
		seq_next    = seq_q;
		wrap_next   = wrap_q;
		emit        = 1'b0;
		res_next    = '0;
		unique case (item_s1.req_type)
			REQ_START: begin
				offset_next = '0;
				seq_next    = '0;
				phase_next  = PH_WAIT;
			end
			REQ_LENGTH: begin
				if (phase_q == PH_WAIT) begin
					offset_next      = room ? next_offset : '0;
					wrap_next        = !room;
					res_next.kind    = KIND_REQUEST;
					res_next.lane[0] = 64'(req_addr[ADDR_BITS-1:0]);
					res_next.lane[1] = 64'(item_s1.msg_length[LEN_BITS-1:0]);
					emit             = 1'b1;
					phase_next       = PH_HEAD;
				end
			end
			REQ_DATA: begin
				if (phase_q != PH_WAIT) begin
					res_next.kind = KIND_DATA;
					res_next.lane = item_s1.lane;
					res_next.keep = item_s1.keep;
					res_next.last = item_s1.last;
					emit          = 1'b1;
					if (phase_q == PH_HEAD) begin
						// header word: wrap flag and sequence number
						res_next.lane[6] = 64'(wrap_q);
						res_next.lane[7] = seq_q;
						seq_next         = seq_q + 64'd1;
						phase_next       = PH_DATA;
					end else if (item_s1.last) begin
						phase_next = PH_WAIT;
					end
				end
			end
			default: ;
		endcase
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			offset_q  <= '0;
			seq_q     <= '0;
			wrap_q    <= 1'b0;
			valid_s2  <= 1'b0;
			result_s2 <= '0;
		end else begin
			if (take) begin
				phase_q  <= phase_next;
				offset_q <= offset_next;
				seq_q    <= seq_next;
				wrap_q   <= wrap_next;
			end
			if (take && emit) begin
				result_s2 <= res_next;
			end
			if (take && emit) begin
				valid_s2 <= 1'b1;
			end else if (valid_s2 && out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Qualifiers for the checks below
	assign len_take  = take && (item_s1.req_type == REQ_LENGTH) && (phase_q == PH_WAIT);
	assign head_take = take && (item_s1.req_type == REQ_DATA) && (phase_q == PH_HEAD);

	`include "assert_macros.svh"

	// The offset always sits on a 64-byte boundary, and a wrapped offset is zero
	`RWSC_ASSERT(a_offset_aligned, offset_q[ALIGN_BITS-1:0] == '0, "offset off 64-byte grid")
	`RWSC_ASSERT(a_wrap_zero, wrap_q |-> offset_q == '0, "offset nonzero after wrap")

	// A length transaction taken while waiting yields a request
	`RWSC_ASSERT(a_len_to_req, len_take |=> valid_s2 && result_s2.kind == KIND_REQUEST, "no request")

	// Sequence number steps by one on every header word
	`RWSC_ASSERT(a_seq_step, head_take |=> seq_q == $past(seq_q) + 64'd1, "sequence did not step")
	`RWSC_ASSERT(a_seq_stamp, head_take |=> result_s2.lane[7] == $past(seq_q), "bad header sequence")

endmodule

// ===== rtl/core/ring_buffer_write_stamper.sv =====
// Top level of the ring buffer write stamper.
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------------
//  input     in_valid / in_ready   req_type, msg_length, in_lane0..7, in_keep, in_last
//  output    out_valid / out_ready out_kind, out_lane0..7, out_keep, out_last
//  config    APB psel/penable      paddr (0 base_address, 8 buffer_size), pwdata, prdata
//
// One transaction per cycle is accepted and processed while the output is not
// stalled; the stamping stage updates the offset, wrap flag and sequence as it
// takes each transaction. A result passes through the input register, then the
// result register, before it is presented.
// A stalled output holds the result register; the input register keeps
// accepting until it too is full.
// Reset clears the offset, sequence, wrap flag, phase, the result register and the input register's valid flag.
module ring_buffer_write_stamper (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rwsc_pkg::PADDR_W-1:0]    paddr,
	input  logic [rwsc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rwsc_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      req_type,
	input  logic [31:0]                     msg_length,
	input  logic [63:0]                     in_lane0,
	input  logic [63:0]                     in_lane1,
	input  logic [63:0]                     in_lane2,
	input  logic [63:0]                     in_lane3,
	input  logic [63:0]                     in_lane4,
	input  logic [63:0]                     in_lane5,
	input  logic [63:0]                     in_lane6,
	input  logic [63:0]                     in_lane7,
	input  logic [63:0]                     in_keep,
	input  logic                            in_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_kind,
	output logic [63:0]                     out_lane0,
	output logic [63:0]                     out_lane1,
	output logic [63:0]                     out_lane2,
	output logic [63:0]                     out_lane3,
	output logic [63:0]                     out_lane4,
	output logic [63:0]                     out_lane5,
	output logic [63:0]                     out_lane6,
	output logic [63:0]                     out_lane7,
	output logic [63:0]                     out_keep,
	output logic                            out_last
);
	import rwsc_pkg::*;

	cfg_t    cfg;
	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    pop_s1;
	result_t result_s2;

	// Gather the input transaction
	assign in_item.req_type   = req_type;
	assign in_item.msg_length = msg_length;
	assign in_item.lane       = {in_lane7, in_lane6, in_lane5, in_lane4,
	                             in_lane3, in_lane2, in_lane1, in_lane0};
	assign in_item.keep       = in_keep;
	assign in_item.last       = in_last;

	rwsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rwsc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1),
		.pop_s1   (pop_s1)
	);

	rwsc_stamp u_stamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item_s1   (item_s1),
		.valid_s1  (valid_s1),
		.pop_s1    (pop_s1),
		.result_s2 (result_s2),
		.valid_s2  (out_valid),
		.out_ready (out_ready)
	);

	// Spread the result onto the output ports
	assign out_kind  = result_s2.kind;
	assign out_lane0 = result_s2.lane[0];
	assign out_lane1 = result_s2.lane[1];
	assign out_lane2 = result_s2.lane[2];
	assign out_lane3 = result_s2.lane[3];
	assign out_lane4 = result_s2.lane[4];
	assign out_lane5 = result_s2.lane[5];
	assign out_lane6 = result_s2.lane[6];
	assign out_lane7 = result_s2.lane[7];
	assign out_keep  = result_s2.keep;
	assign out_last  = result_s2.last;

endmodule
